FILE: design/rvr_pkg.sv
// Package for the Rodrigues vector rotation block.
// Holds the shared widths, pipeline latencies, angle constants and the CORDIC arctangent table.
// Used by every module in the design folder; depends on nothing.
package rvr_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF   = 16;

  localparam int ANGLE_W = 16;
  localparam int UNIT_W  = 16;
  localparam int CS_W    = 20;

  localparam int NORM_LAT = 54;
  localparam int COMB_LAT = 6;

  localparam logic signed [UNIT_W-1:0] Q14_ONE = 16'sd16384;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h3243F6A8;
      1:       val = 32'h1DAC6705;
      2:       val = 32'h0FADBAFC;
      3:       val = 32'h07F56EA6;
      4:       val = 32'h03FEAB76;
      5:       val = 32'h01FFD55B;
      6:       val = 32'h00FFFAAA;
      7:       val = 32'h007FFF55;
      8:       val = 32'h003FFFEA;
      9:       val = 32'h001FFFFD;
      10:      val = 32'h000FFFFF;
      11:      val = 32'h0007FFFF;
      12:      val = 32'h0003FFFF;
      13:      val = 32'h0001FFFF;
      14:      val = 32'h0000FFFF;
      15:      val = 32'h00007FFF;
      16:      val = 32'h00003FFF;
      17:      val = 32'h00001FFF;
      18:      val = 32'h00000FFF;
      19:      val = 32'h000007FF;
      20:      val = 32'h000003FF;
      21:      val = 32'h000001FF;
      22:      val = 32'h000000FF;
      23:      val = 32'h0000007F;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

FILE: design/rvr_norm.sv
// Unit-length scaling of one three-component vector to Q1.14.
// Squares and sum, leading-one search, even scaling, 31-stage square root, 16-stage dividers.
// Depends on rvr_pkg.
module rvr_norm import rvr_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [2:0][COMPONENT_BITS-1:0]     comp_i,
  output logic [2:0][UNIT_W-1:0]             unit_o
);

  localparam int W    = COMPONENT_BITS;
  localparam int DW   = 52;
  localparam int SQW  = 63;
  localparam int NSQ  = 31;
  localparam int NDIV = 16;

  typedef struct packed {
    logic                  zero;
    logic signed [6:0]     e;
    logic [2:0]            neg;
    logic [2:0][W-1:0]     mag;
  } side_t;

  function automatic logic [3:0] lead16(input logic [15:0] v);
    logic [3:0] pos;
    pos = '0;
    for (int b = 0; b < 16; b++) begin
      if (v[b]) pos = 4'(b);
    end
    return pos;
  endfunction

  logic [2:0][2*W-1:0] sq_q;
  side_t               sd1_q, sd2_q, sd3_q, sd4_q;
  logic [63:0]         sum2_q, sum3_q, sum4_q;
  logic [3:0]          nz3_q;
  logic [3:0][3:0]     pos3_q;

  logic [SQW-1:0]      sn_q  [NSQ+1];
  logic [SQW-1:0]      sr_q  [NSQ+1];
  side_t               sds_q [NSQ+1];

  logic [DW-1:0]       rm_q  [NDIV+1][3];
  logic [DW-1:0]       dd_q  [NDIV+1][3];
  logic [UNIT_W-1:0]   qq_q  [NDIV+1][3];
  side_t               sdd_q [NDIV+1];

  logic [2:0][UNIT_W-1:0] unit_q;

  side_t       sd1_d;
  side_t       sd4_d;
  logic [5:0]  p4_d;
  logic        z4_d;
  logic signed [7:0] ed4_d;

  always_comb begin
    sd1_d = '0;
    for (int i = 0; i < 3; i++) begin
      sd1_d.neg[i] = comp_i[i][W-1];
      sd1_d.mag[i] = comp_i[i][W-1] ? (~comp_i[i] + W'(1)) : comp_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*W)'($signed(comp_i[i]) * $signed(comp_i[i]));
      end
      sd1_q  <= sd1_d;
      sum2_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      sd2_q  <= sd1_q;
      for (int c = 0; c < 4; c++) begin
        nz3_q[c]  <= |sum2_q[16*c +: 16];
        pos3_q[c] <= lead16(sum2_q[16*c +: 16]);
      end
      sum3_q <= sum2_q;
      sd3_q  <= sd2_q;
    end
  end

  always_comb begin
    p4_d = '0;
    z4_d = 1'b1;
    for (int c = 0; c < 4; c++) begin
      if (nz3_q[c]) begin
        p4_d = {2'(c), pos3_q[c]};
        z4_d = 1'b0;
      end
    end
    ed4_d = $signed({2'b00, p4_d}) - 8'sd60;
    sd4_d      = sd3_q;
    sd4_d.zero = z4_d;
    sd4_d.e    = z4_d ? 7'sd0 : 7'(ed4_d >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd4_q      <= sd4_d;
      sum4_q     <= sum3_q;
      if (sd4_q.e >= 0) begin
        sn_q[0] <= SQW'(sum4_q >> (2 * sd4_q.e));
      end else begin
        sn_q[0] <= SQW'(sum4_q << (-2 * sd4_q.e));
      end
      sr_q[0]  <= '0;
      sds_q[0] <= sd4_q;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NSQ - 1 - k));
    logic [SQW-1:0] trial;
    assign trial = sr_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sn_q[k] >= trial) begin
          sn_q[k+1] <= sn_q[k] - trial;
          sr_q[k+1] <= (sr_q[k] >> 1) + BIT;
        end else begin
          sn_q[k+1] <= sn_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
        sds_q[k+1] <= sds_q[k];
      end
    end
  end

  logic [DW-1:0] root;
  logic [5:0]    nsh;
  logic [DW-1:0] den [3];
  logic [DW-1:0] num [3];

  always_comb begin
    root = DW'(sr_q[NSQ]);
    nsh  = (sds_q[NSQ].e >= 0) ? 6'd14 : 6'(7'sd14 - sds_q[NSQ].e);
    for (int i = 0; i < 3; i++) begin
      den[i] = (sds_q[NSQ].e >= 0) ? (root << sds_q[NSQ].e[0]) : root;
      num[i] = DW'(sds_q[NSQ].mag[i]) << nsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rm_q[0][i] <= (num[i] << 1) + den[i];
        dd_q[0][i] <= den[i] << 1;
        qq_q[0][i] <= '0;
      end
      sdd_q[0] <= sds_q[NSQ];
    end
  end

  for (genvar t = 0; t < NDIV; t++) begin : g_div
    localparam int J = NDIV - 1 - t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dd_q[t+1][i] <= dd_q[t][i];
          if (rm_q[t][i] >= (dd_q[t][i] << J)) begin
            rm_q[t+1][i] <= rm_q[t][i] - (dd_q[t][i] << J);
            qq_q[t+1][i] <= qq_q[t][i] | (UNIT_W'(1) << J);
          end else begin
            rm_q[t+1][i] <= rm_q[t][i];
            qq_q[t+1][i] <= qq_q[t][i];
          end
        end
        sdd_q[t+1] <= sdd_q[t];
      end
    end
  end

  logic [UNIT_W-1:0] qc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (qq_q[NDIV][i] > Q14_ONE) ? Q14_ONE : qq_q[NDIV][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (sdd_q[NDIV].zero) begin
          unit_q[i] <= '0;
        end else if (sdd_q[NDIV].neg[i]) begin
          unit_q[i] <= ~qc[i] + UNIT_W'(1);
        end else begin
          unit_q[i] <= qc[i];
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

FILE: design/rvr_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a Q2.13 angle in Q16.
// One range-reduction stage, one stage per iteration, one rounding stage.
// Depends on rvr_pkg.
module rvr_cordic import rvr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ANGLE_W-1:0]     angle_i,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  localparam int ZW = 36;
  localparam int XW = 34;

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
  logic                 f_q [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] cos_q, sin_q;

  logic signed [ZW-1:0] z0;
  assign z0 = ZW'($signed(angle_i)) <<< 17;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GAIN_Q30;
      y_q[0] <= '0;
      if (z0 > HALF_PI_Q30) begin
        z_q[0] <= z0 - PI_Q30;
        f_q[0] <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_q[0] <= z0 + PI_Q30;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z0;
        f_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATN = ZW'(atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATN;
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  logic signed [XW-1:0] xf, yf;
  always_comb begin
    xf = f_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    yf = f_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= CS_W'((xf + XW'(8192)) >>> 14);
      sin_q <= CS_W'((yf + XW'(8192)) >>> 14);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

FILE: design/rvr_comb.sv
// Rodrigues sum of the unit vector, unit axis, cosine and sine in six pipeline stages.
// Cross and dot products, scaled terms, split wide product, exact sum, rounding and clamp.
// Depends on rvr_pkg.
module rvr_comb import rvr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2:0][UNIT_W-1:0] v_i,
  input  logic [2:0][UNIT_W-1:0] k_i,
  input  logic signed [CS_W-1:0] cos_i,
  input  logic signed [CS_W-1:0] sin_i,
  output logic [2:0][UNIT_W-1:0] out_o
);

  logic signed [35:0] pv1_q [3], pv2_q [3], pv3_q [3], pv4_q [3];
  logic signed [31:0] ma_q [3], mb_q [3], md_q [3];
  logic [2:0][UNIT_W-1:0] k1_q, k2_q;
  logic signed [CS_W-1:0] s1_q, s2_q;
  logic signed [CS_W:0]   omc1_q, omc2_q, omc3_q;
  logic signed [32:0]     cr2_q [3];
  logic signed [33:0]     dot2_q;
  logic signed [52:0]     t2_3_q [3], t2_4_q [3];
  logic signed [49:0]     kd3_q [3];
  logic signed [46:0]     ph4_q [3];
  logic signed [46:0]     pl4_q [3];
  logic signed [63:0]     t3_5_q [3], s12_5_q [3];
  logic [2:0][UNIT_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pv1_q[i] <= $signed(v_i[i]) * cos_i;
        md_q[i]  <= $signed(k_i[i]) * $signed(v_i[i]);
      end
      ma_q[0] <= $signed(k_i[1]) * $signed(v_i[2]);
      mb_q[0] <= $signed(k_i[2]) * $signed(v_i[1]);
      ma_q[1] <= $signed(k_i[2]) * $signed(v_i[0]);
      mb_q[1] <= $signed(k_i[0]) * $signed(v_i[2]);
      ma_q[2] <= $signed(k_i[0]) * $signed(v_i[1]);
      mb_q[2] <= $signed(k_i[1]) * $signed(v_i[0]);
      k1_q    <= k_i;
      s1_q    <= sin_i;
      omc1_q  <= (CS_W+1)'(65536) - (CS_W+1)'(cos_i);

      for (int i = 0; i < 3; i++) begin
        cr2_q[i] <= 33'(ma_q[i]) - 33'(mb_q[i]);
        pv2_q[i] <= pv1_q[i];
      end
      dot2_q <= 34'(md_q[0]) + 34'(md_q[1]) + 34'(md_q[2]);
      k2_q   <= k1_q;
      s2_q   <= s1_q;
      omc2_q <= omc1_q;

      for (int i = 0; i < 3; i++) begin
        t2_3_q[i] <= cr2_q[i] * s2_q;
        kd3_q[i]  <= $signed(k2_q[i]) * dot2_q;
        pv3_q[i]  <= pv2_q[i];
      end
      omc3_q <= omc2_q;

      for (int i = 0; i < 3; i++) begin
        ph4_q[i]  <= 47'($signed(kd3_q[i][49:24]) * omc3_q);
        pl4_q[i]  <= 47'($signed({1'b0, kd3_q[i][23:0]}) * omc3_q);
        t2_4_q[i] <= t2_3_q[i];
        pv4_q[i]  <= pv3_q[i];
      end

      for (int i = 0; i < 3; i++) begin
        t3_5_q[i]  <= (64'(ph4_q[i]) <<< 24) + 64'(pl4_q[i]);
        s12_5_q[i] <= (64'(pv4_q[i]) <<< 28) + (64'(t2_4_q[i]) <<< 14);
      end
    end
  end

  logic signed [63:0] tot [3];
  logic signed [19:0] rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = s12_5_q[i] + t3_5_q[i] + (64'sd1 <<< 43);
      rnd[i] = 20'(tot[i] >>> 44);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (rnd[i] > 20'sd16384) begin
          out_q[i] <= Q14_ONE;
        end else if (rnd[i] < -20'sd16384) begin
          out_q[i] <= -Q14_ONE;
        end else begin
          out_q[i] <= rnd[i][UNIT_W-1:0];
        end
      end
    end
  end

  assign out_o = out_q;

endmodule

FILE: design/rodrigues_vector_rotation.sv
// Top level of the Rodrigues vector rotation block: stream ports, stall control and alignment.
// Instantiates rvr_norm twice, rvr_cordic and rvr_comb; depends on rvr_pkg.
//
// Channel   Direction  Width (default)  Content
// s_axis    in         112 bits         vector, axis and angle request
// m_axis    out        48 bits          rotated unit vector
//
// One request enters per cycle while the pipeline advances; each result passes through the
// 31-stage square root and 16-stage dividers of the scaling pipeline, then the combination stages.
// The whole pipeline advances unless a valid result is held against a low m_axis_tready.
// Reset clears only the valid bits; payload registers are not reset.
module rodrigues_vector_rotation import rvr_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle, zero fill
  input  logic [((6*COMPONENT_BITS+ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_x, out_y, out_z
  output logic [3*UNIT_W-1:0] m_axis_tdata
);

  localparam int W   = COMPONENT_BITS;
  localparam int LAT = NORM_LAT + COMB_LAT;
  localparam int DLY = NORM_LAT - (CORDIC_STEPS + 2);

  logic                   en;
  logic [LAT-1:0]         vld_q;
  logic [2:0][W-1:0]      vec, axs;
  logic [2:0][UNIT_W-1:0] v_unit, k_unit, res;
  logic [ANGLE_W-1:0]     ang_q [DLY];
  logic signed [CS_W-1:0] cos_w, sin_w;

  assign en            = ~vld_q[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec[i] = s_axis_tdata[W*i +: W];
      axs[i] = s_axis_tdata[W*(3+i) +: W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= s_axis_tdata[6*W +: ANGLE_W];
      for (int d = 1; d < DLY; d++) begin
        ang_q[d] <= ang_q[d-1];
      end
    end
  end

  rvr_norm #(.COMPONENT_BITS(W)) u_norm_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .comp_i(vec),
    .unit_o(v_unit)
  );

  rvr_norm #(.COMPONENT_BITS(W)) u_norm_axis (
    .clk_i (clk_i),
    .en_i  (en),
    .comp_i(axs),
    .unit_o(k_unit)
  );

  rvr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(ang_q[DLY-1]),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  rvr_comb u_comb (
    .clk_i(clk_i),
    .en_i (en),
    .v_i  (v_unit),
    .k_i  (k_unit),
    .cos_i(cos_w),
    .sin_i(sin_w),
    .out_o(res)
  );

  assign m_axis_tdata = res;

endmodule

FILE: tb/sv/rodrigues_vector_rotation_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rodrigues_vector_rotation: random and directed vector rotation
// requests, with the unit-vector result predicted in SystemVerilog and compared per field.
// Depends on rvr_pkg and the design files only.
module rodrigues_vector_rotation_test;
  import rvr_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int IN_W = ((6*CB+ANGLE_W+7)/8)*8;
  localparam int OUT_W = 3*UNIT_W;
  localparam int SETTLE_CYCLES = NORM_LAT + COMB_LAT + 20;
  localparam int STALL_LIMIT = 4000;
  localparam longint ONE_Q14 = 16384;

  typedef longint trio_t [3];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [IN_W-1:0] pending_requests[$];
  logic [OUT_W-1:0] expected_vectors[$];
  int tx_idle = 9;
  int rx_idle = 77;
  int issued = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;
  bit s_took = 1'b0;

  rodrigues_vector_rotation u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic trio_t unit_q14(input trio_t c);
    trio_t u;
    longint unsigned s, m, r, a, num, den, q;
    int e;
    s = 0;
    e = 0;
    for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
    if (s == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return u;
    end
    m = s;
    while (m >= (64'd1 << 62)) begin m = m >> 2; e++; end
    while (m < (64'd1 << 60)) begin m = m << 2; e--; end
    r = int_sqrt(m);
    for (int i = 0; i < 3; i++) begin
      a = (c[i] < 0) ? -c[i] : c[i];
      if (e >= 0) begin
        num = a << 14;
        den = r << e;
      end else begin
        num = a << (14 - e);
        den = r;
      end
      q = (2 * num + den) / (2 * den);
      if (q > ONE_Q14) q = ONE_Q14;
      u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic void sin_cos_q16(input logic signed [15:0] ang, output longint cq,
                                      output longint sq);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * (64'sd1 <<< 17);
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_q30(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cq = (x + (64'sd1 <<< 13)) >>> 14;
    sq = (y + (64'sd1 <<< 13)) >>> 14;
  endfunction

  function automatic logic [OUT_W-1:0] rotate_vector(input logic [IN_W-1:0] d);
    trio_t vr, kr, v, k, cr;
    longint c, s, dot, omc, t1, t2, t3, r;
    logic [OUT_W-1:0] res;
    for (int i = 0; i < 3; i++) begin
      vr[i] = longint'($signed(d[i*CB +: CB]));
      kr[i] = longint'($signed(d[(3+i)*CB +: CB]));
    end
    v = unit_q14(vr);
    k = unit_q14(kr);
    sin_cos_q16(d[6*CB +: ANGLE_W], c, s);
    cr[0] = k[1] * v[2] - k[2] * v[1];
    cr[1] = k[2] * v[0] - k[0] * v[2];
    cr[2] = k[0] * v[1] - k[1] * v[0];
    dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
    omc = (64'sd1 <<< 16) - c;
    for (int i = 0; i < 3; i++) begin
      t1 = v[i] * c * (64'sd1 <<< 28);
      t2 = cr[i] * s * (64'sd1 <<< 14);
      t3 = k[i] * dot * omc;
      r = (t1 + t2 + t3 + (64'sd1 <<< 43)) >>> 44;
      if (r > ONE_Q14) r = ONE_Q14;
      if (r < -ONE_Q14) r = -ONE_Q14;
      res[i*UNIT_W +: UNIT_W] = r[UNIT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_request(input int vx, vy, vz, kx, ky, kz,
                                                   input int ang);
    logic [IN_W-1:0] d;
    d = '0;
    d[0*CB +: CB] = CB'(vx);
    d[1*CB +: CB] = CB'(vy);
    d[2*CB +: CB] = CB'(vz);
    d[3*CB +: CB] = CB'(kx);
    d[4*CB +: CB] = CB'(ky);
    d[5*CB +: CB] = CB'(kz);
    d[6*CB +: ANGLE_W] = ANGLE_W'(ang);
    return d;
  endfunction

  function automatic logic [15:0] random_component();
    case ($urandom_range(5))
      0: return 16'($signed($urandom_range(6)) - 3);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_took) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_requests.pop_front();
          issued++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && issued >= 520) begin
        hold_done = 1'b1;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    s_took <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) expected_vectors.push_back(rotate_vector(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_vectors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [OUT_W-1:0] want;
        want = expected_vectors.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (want[i*UNIT_W +: UNIT_W] !== m_axis_tdata[i*UNIT_W +: UNIT_W]) begin
            $display("%0t: field %0d mismatch, expected %0d, actual %0d", $time, i,
                     $signed(want[i*UNIT_W +: UNIT_W]), $signed(m_axis_tdata[i*UNIT_W +: UNIT_W]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("rodrigues_vector_rotation_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int angles[6];
    angles = '{0, 25736, -25736, 12868, -12868, 32767};
    // Zero vector, zero axis, extreme components and angles across the whole field.
    pending_requests.push_back(pack_request(0, 0, 0, 1, 2, 3, 16'd5000));
    pending_requests.push_back(pack_request(100, -50, 7, 0, 0, 0, 16'd8000));
    pending_requests.push_back(pack_request(0, 0, 0, 0, 0, 0, 16'h8000));
    pending_requests.push_back(pack_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                            16'h8000, 16'd1000));
    pending_requests.push_back(pack_request(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 0,
                                            16'hE000));
    pending_requests.push_back(pack_request(1, 0, 0, 0, 0, 1, 16'd12868));
    pending_requests.push_back(pack_request(1, 0, 0, 0, 0, 16'hFFFF, 16'd12868));
    pending_requests.push_back(pack_request(0, 1, 0, 1, 0, 0, 16'h8000));
    pending_requests.push_back(pack_request(0, 0, 1, 0, 1, 0, 16'h7FFF));
    pending_requests.push_back(pack_request(3, 4, 0, 1, 1, 1, 16'd25736));
    pending_requests.push_back(pack_request(-3, 4, -5, 5, -4, 3, -25736));
    pending_requests.push_back(pack_request(16'h8000, 0, 0, 16'h8000, 0, 0, 16'd20000));
    for (int i = 0; i < 6; i++) begin
      pending_requests.push_back(pack_request(16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h5555,
                                              16'hAAAA, angles[i]));
    end
    for (int i = 0; i < 700; i++) begin
      logic [15:0] ang;
      if ($urandom_range(9) == 0) ang = 16'($urandom);
      else ang = 16'($signed($urandom_range(51472)) - 25736);
      pending_requests.push_back(pack_request(random_component(), random_component(),
        random_component(), random_component(), random_component(), random_component(), ang));
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (issued >= 240);
    tx_idle = 77;
    rx_idle = 9;
    wait (issued >= 480);
    tx_idle = 0;
    rx_idle = 0;
    wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_vectors.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("rodrigues_vector_rotation_test: clean");
    end else begin
      $display("rodrigues_vector_rotation_test: errors");
    end
    $finish;
  end

endmodule
